FILE: rtl/hmsc_pkg.sv
// ----------------------------------------------------------------------------
// hmsc_pkg: shared types and constants for the countdown alarm ringer
// Holds the command codes, the saturation limit and the state/result records.
// ----------------------------------------------------------------------------
package hmsc_pkg;

   // Command codes carried in the kind field of an input item.
   localparam logic [2:0] KIND_SEC_TICK  = 3'd0;
   localparam logic [2:0] KIND_POLL_TICK = 3'd1;
   localparam logic [2:0] KIND_LOAD      = 3'd2;
   localparam logic [2:0] KIND_START     = 3'd3;
   localparam logic [2:0] KIND_PAUSE     = 3'd4;
   localparam logic [2:0] KIND_RESET     = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RING_COUNT    = 2'd0;
   localparam logic [1:0] CSR_RING_INTERVAL = 2'd1;

   // Largest legal minute or second value.
   localparam logic [5:0] MAX_MS = 6'd59;

   // Configuration reset values.
   localparam logic [3:0] RING_COUNT_RESET    = 4'd3;
   localparam logic [3:0] RING_INTERVAL_RESET = 4'd2;

   typedef struct packed {
      logic [7:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       enabled;
      logic       ring_pending;
      logic [3:0] rings_sent;
      logic [3:0] ring_wait;
   } timer_state_type;

   typedef struct packed {
      logic [7:0] left_hour;
      logic [5:0] left_minute;
      logic [5:0] left_second;
      logic       counting;
      logic       timed_out;
      logic       ring_now;
      logic       ringing;
   } result_type;

endpackage

FILE: rtl/hmsc_step.sv
// ----------------------------------------------------------------------------
// hmsc_step: next-state logic of the countdown alarm
// Applies one command to the timer and ring state and forms the result item.
// ----------------------------------------------------------------------------
module hmsc_step (
   input  hmsc_pkg::timer_state_type state,
   input  logic [2:0]                kind,
   input  logic [7:0]                load_hour,
   input  logic [5:0]                load_minute,
   input  logic [5:0]                load_second,
   input  logic [3:0]                ring_count,
   input  logic [3:0]                ring_interval,
   output hmsc_pkg::timer_state_type next_state,
   output hmsc_pkg::result_type      result
);
   import hmsc_pkg::*;

   function automatic logic [5:0] sat59(input logic [5:0] v);
      return (v > MAX_MS) ? MAX_MS : v;
   endfunction

   always_comb begin
      timer_state_type nxt;
      logic            time_zero;
      logic            timed_out;
      logic            ring_now;
      logic [3:0]      sent_inc;

      nxt       = state;
      timed_out = 1'b0;
      ring_now  = 1'b0;
      time_zero = (state.hours == 8'd0) && (state.minutes == 6'd0) &&
                  (state.seconds == 6'd0);
      sent_inc  = state.rings_sent + 4'd1;

      case (kind)
         KIND_SEC_TICK: begin
            if (state.enabled) begin
               if (time_zero) begin
                  nxt.enabled      = 1'b0;
                  nxt.ring_pending = 1'b1;
                  nxt.rings_sent   = 4'd0;
                  nxt.ring_wait    = 4'd0;
                  timed_out        = 1'b1;
               end else if (state.seconds != 6'd0) begin
                  nxt.seconds = state.seconds - 6'd1;
               end else begin
                  // Borrow from minutes, then from hours.
                  nxt.seconds = MAX_MS;
                  if (state.minutes != 6'd0) begin
                     nxt.minutes = state.minutes - 6'd1;
                  end else if (state.hours != 8'd0) begin
                     nxt.minutes = MAX_MS;
                     nxt.hours   = state.hours - 8'd1;
                  end
               end
            end
         end
         KIND_POLL_TICK: begin
            if (state.ring_pending) begin
               if (state.ring_wait != 4'd0) begin
                  nxt.ring_wait = state.ring_wait - 4'd1;
               end else begin
                  ring_now       = 1'b1;
                  nxt.rings_sent = sent_inc;
                  if (sent_inc >= ring_count) begin
                     nxt.ring_pending = 1'b0;
                  end else begin
                     nxt.ring_wait = ring_interval;
                  end
               end
            end
         end
         KIND_LOAD: begin
            nxt.hours   = load_hour;
            nxt.minutes = sat59(load_minute);
            nxt.seconds = sat59(load_second);
            nxt.enabled = 1'b1;
         end
         KIND_START: begin
            nxt.enabled = 1'b1;
         end
         KIND_PAUSE: begin
            nxt.enabled = 1'b0;
         end
         KIND_RESET: begin
            nxt.hours   = 8'd0;
            nxt.minutes = 6'd0;
            nxt.seconds = 6'd0;
            nxt.enabled = 1'b0;
         end
         default: begin
         end
      endcase

      next_state         = nxt;
      result.left_hour   = nxt.hours;
      result.left_minute = nxt.minutes;
      result.left_second = nxt.seconds;
      result.counting    = nxt.enabled;
      result.timed_out   = timed_out;
      result.ring_now    = ring_now;
      result.ringing     = nxt.ring_pending;
   end

endmodule

FILE: rtl/hms_countdown_alarm_ringer.sv
// ----------------------------------------------------------------------------
// hms_countdown_alarm_ringer: hours:minutes:seconds countdown with alarm ring
// Top level with the command stream, the result stream and the register port.
// ----------------------------------------------------------------------------
// The block takes one command item per clock while ready and returns exactly
// one result item for each, in the cycle after acceptance. Throughput is one
// item per cycle, set by the single result register: req_tready is high
// whenever that register is empty or its item is being taken in the same
// cycle, so a new command enters while the previous result is handed over.
// The timer and ring state are updated at the edge that accepts a command, and
// the result reports the state after that command. The ring registers may be
// written at any edge through csr_we; writes to indexes above one are dropped.
module hms_countdown_alarm_ringer (
   input  logic        clock,
   input  logic        reset,
   // Command stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // load_hour[7:0], load_minute[13:8],
                                   // load_second[19:14], zero fill[23:20]
   input  logic [2:0]  req_tuser,  // kind[2:0]
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // left_hour[7:0], left_minute[13:8],
                                   // left_second[19:14], counting[20],
                                   // timed_out[21], ring_now[22], ringing[23]
   // Register write port.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   import hmsc_pkg::*;

   timer_state_type state_ff;
   timer_state_type state_in;
   result_type      result_in;
   result_type      result_ff;
   logic            rsp_valid_ff;
   logic [3:0]      ring_count_ff;
   logic [3:0]      ring_interval_ff;
   logic            req_accept;

   // The result register frees up in the same cycle that its item is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   hmsc_step u_step (
      .state         (state_ff),
      .kind          (req_tuser),
      .load_hour     (req_tdata[7:0]),
      .load_minute   (req_tdata[13:8]),
      .load_second   (req_tdata[19:14]),
      .ring_count    (ring_count_ff),
      .ring_interval (ring_interval_ff),
      .next_state    (state_in),
      .result        (result_in)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff    <= RING_COUNT_RESET;
         ring_interval_ff <= RING_INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RING_COUNT:    ring_count_ff    <= csr_wdata;
            CSR_RING_INTERVAL: ring_interval_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Timer and ring state advance once per accepted command.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Result register: the valid flag is control, the payload is not reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {result_ff.ringing, result_ff.ring_now, result_ff.timed_out,
                        result_ff.counting, result_ff.left_second,
                        result_ff.left_minute, result_ff.left_hour};

endmodule

FILE: rtl/hmsc_checker.sv
// ----------------------------------------------------------------------------
// hmsc_checker: port-level checks for the countdown alarm ringer
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module hmsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   // Every accepted command yields a result item in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted command produced no result");

   // With no result waiting, the block must take commands.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("block stalled with an empty result register");

   // A timeout stops the count and arms the ring, and never rings itself.
   a_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> !rsp_tdata[20] && rsp_tdata[23] && !rsp_tdata[22])
      else $error("timeout result inconsistent");

endmodule

bind hms_countdown_alarm_ringer hmsc_checker u_hmsc_checker (.*);
